FILE: rtl/ksl_pkg.sv
// Shared constants and types for the keyed sequential list.
// No dependencies; imported by keyed_sequential_list and its testbench.
`timescale 1ns / 1ps
`default_nettype none

package ksl_pkg;

    // Fixed field widths of the request and result channels
    localparam int FUNC_W = 3;
    localparam int CNT_W  = 7;
    localparam int MAC_W  = 64;
    localparam int ID_W   = 32;
    localparam int PAY_W  = 32;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF        = 64;
    localparam int PAYLOAD_BITS_DEF = 32;

    // Capacity after reset
    localparam logic [CNT_W-1:0] CAP_RST = 7'd64;

    typedef logic [FUNC_W-1:0] t_func;

    // Operation codes
    localparam t_func FN_ADD = 3'd0;
    localparam t_func FN_DEL = 3'd1;
    localparam t_func FN_GET = 3'd2;
    localparam t_func FN_LOC = 3'd3;
    localparam t_func FN_CLR = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/keyed_sequential_list.sv
// Keyed sequential list: packed entry store with add, delete, get, locate, clear.
// Depends on ksl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A packed list of up to DEPTH entries, each a 64-bit MAC, a 32-bit ID and a
// payload word of PAYLOAD_BITS bits (at most 32 are kept). One request at a
// time is executed; a finished result waits in the output register while the
// next request is taken in. Add, clear, get, a refused request and the unused
// codes go from decode straight to the done state. Locate walks every
// stored entry through the single read port of the entry memory, one per
// cycle, and then drains the read pipe. Delete copies each later entry down
// one place through the same port. The next request is taken in the cycle
// after the result is handed to the output register; a result that is not
// taken holds the sequencer until the output register frees. Capacity is
// written through i_cfg_we / i_cfg_wdata, which the user must do only while
// the block is idle; the block itself does not enforce this. The capacity is
// clipped to DEPTH. The entry memory is not cleared after reset; only the
// count is, and no request ever reads beyond it.
module keyed_sequential_list
    import ksl_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [CNT_W-1:0]   i_cfg_wdata,
    // request channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [FUNC_W-1:0]  i_func,
    input  wire logic [CNT_W-1:0]   i_position,
    input  wire logic [MAC_W-1:0]   i_key_mac,
    input  wire logic [ID_W-1:0]    i_key_id,
    input  wire logic [PAY_W-1:0]   i_payload,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_ok,
    output logic [CNT_W-1:0]        o_found_position,
    output logic [MAC_W-1:0]        o_out_mac,
    output logic [ID_W-1:0]         o_out_id,
    output logic [PAY_W-1:0]        o_out_payload,
    output logic [CNT_W-1:0]        o_count,
    output logic                    o_empty_res
);

    // Counter width: holds DEPTH itself, never narrower than the port fields
    localparam int CW = ($clog2(DEPTH + 1) > CNT_W) ? $clog2(DEPTH + 1) : CNT_W;
    // Memory address width
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Stored payload width
    localparam int SW = (PAYLOAD_BITS < PAY_W) ? PAYLOAD_BITS : PAY_W;
    // Entry word: MAC | ID | payload
    localparam int EW = MAC_W + ID_W + SW;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;  // decode, single-step ops
    localparam logic [2:0] S_LOC  = 3'd2;  // locate scan
    localparam logic [2:0] S_DEL  = 3'd3;  // delete shift-down
    localparam logic [2:0] S_DONE = 3'd4;  // hand result to output register

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cap;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;            // next entry to read
    logic              r_pend, n_pend;          // read data of r_pend_idx is due
    logic [CW-1:0]     r_pend_idx, n_pend_idx;
    logic [CW-1:0]     r_found, n_found;
    logic              r_ok, n_ok;

    // latched request
    t_func             r_func;
    logic [CNT_W-1:0]  r_pos;
    logic [MAC_W-1:0]  r_mac;
    logic [ID_W-1:0]   r_id;
    logic [SW-1:0]     r_pay;

    // result register
    logic              r_out_valid;
    logic              r_o_ok;
    logic [CNT_W-1:0]  r_o_found;
    logic [MAC_W-1:0]  r_o_mac;
    logic [ID_W-1:0]   r_o_id;
    logic [PAY_W-1:0]  r_o_pay;
    logic [CNT_W-1:0]  r_o_count;
    logic              r_o_empty;

    // entry memory, one write and one registered read port
    logic [EW-1:0]     r_mem [DEPTH];
    logic [EW-1:0]     r_rd_data;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [EW-1:0]     wr_data;

    // ---------------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------------
    logic              in_acc;
    logic              out_free;
    logic [CW-1:0]     cap_ext, cap_eff;
    logic [CW-1:0]     pos_ext, pos_m1;
    logic [CW-1:0]     pend_m1, pend_p1;
    logic              pos_good;
    logic              key_hit;
    logic              get_hit;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign cap_ext  = CW'(r_cap);
    assign cap_eff  = (cap_ext < CW'(DEPTH)) ? cap_ext : CW'(DEPTH);
    assign pos_ext  = CW'(r_pos);
    assign pos_m1   = pos_ext - CW'(1);
    assign pend_m1  = r_pend_idx - CW'(1);
    assign pend_p1  = r_pend_idx + CW'(1);
    // count never exceeds DEPTH, so this also bounds the position
    assign pos_good = (r_pos != '0) && (pos_ext <= r_count);

    assign key_hit  = (r_rd_data[EW-1 -: MAC_W] == r_mac)
                   && (r_rd_data[ID_W+SW-1 -: ID_W] == r_id);
    assign get_hit  = (r_func == FN_GET) && r_ok;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_found    = r_found;
        n_ok       = r_ok;
        rd_en      = 1'b0;
        rd_addr    = r_idx[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_count[AW-1:0];
        wr_data    = {r_mac, r_id, r_pay};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_EXEC;
                    n_ok    = 1'b0;
                    n_found = '0;
                    n_pend  = 1'b0;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_func)
                    FN_ADD: begin
                        if (r_count < cap_eff) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CW'(1);
                            n_ok    = 1'b1;
                        end
                    end
                    FN_DEL: begin
                        if (pos_good) begin
                            n_idx   = pos_ext;   // first entry to move down
                            n_state = S_DEL;
                        end
                    end
                    FN_GET: begin
                        if (pos_good) begin
                            rd_en   = 1'b1;
                            rd_addr = pos_m1[AW-1:0];
                            n_ok    = 1'b1;
                        end
                    end
                    FN_LOC: begin
                        n_idx   = '0;
                        n_state = S_LOC;
                    end
                    FN_CLR: begin
                        n_count = '0;
                        n_ok    = 1'b1;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            S_LOC: begin
                if (r_idx < r_count) begin
                    rd_en      = 1'b1;
                    n_idx      = r_idx + CW'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                end else begin
                    n_pend = 1'b0;
                end
                // later hits overwrite earlier ones: last match wins
                if (r_pend && key_hit) begin
                    n_found = pend_p1;
                end
                if (!r_pend && (r_idx >= r_count)) begin
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DEL: begin
                if (r_idx < r_count) begin
                    rd_en      = 1'b1;
                    n_idx      = r_idx + CW'(1);
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                end else begin
                    n_pend = 1'b0;
                end
                // write trails the read address by two entries, so it never hits the read slot
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = pend_m1[AW-1:0];
                    wr_data = r_rd_data;
                end
                if (!r_pend && (r_idx >= r_count)) begin
                    n_count = r_count - CW'(1);
                    n_ok    = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CAP_RST;
            r_count     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_idx  <= '0;
            r_found     <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_pend_idx <= n_pend_idx;
            r_found    <= n_found;
            r_ok       <= n_ok;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_mac  <= i_key_mac;
            r_id   <= i_key_id;
            r_pay  <= i_payload[SW-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_o_ok    <= r_ok;
            r_o_found <= r_found[CNT_W-1:0];
            r_o_mac   <= get_hit ? r_rd_data[EW-1 -: MAC_W] : '0;
            r_o_id    <= get_hit ? r_rd_data[ID_W+SW-1 -: ID_W] : '0;
            r_o_pay   <= get_hit ? PAY_W'(r_rd_data[SW-1:0]) : '0;
            r_o_count <= r_count[CNT_W-1:0];
            r_o_empty <= (r_count == '0);
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_ok             = r_o_ok;
    assign o_found_position = r_o_found;
    assign o_out_mac        = r_o_mac;
    assign o_out_id         = r_o_id;
    assign o_out_payload    = r_o_pay;
    assign o_count          = r_o_count;
    assign o_empty_res      = r_o_empty;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write to the same entry in one cycle");

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ((r_state == S_LOC) || (r_state == S_DEL)))
        else $error("read left pending outside a scan");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside the done state");

endmodule

`default_nettype wire

FILE: tb/keyed_sequential_list_test.sv
// Self-checking testbench for keyed_sequential_list: directed table, then random phases.
// Depends on ksl_pkg and the keyed_sequential_list RTL; nothing else.
`timescale 1ns / 1ps

module keyed_sequential_list_test;
    import ksl_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int PAYLOAD_BITS = PAYLOAD_BITS_DEF;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DIR_ROWS     = 25;
    localparam int PHASES       = 8;
    localparam int MAX_REPORTS  = 100;

    // func codes the block does not implement: they must come back as no-ops
    localparam t_func FN_SPARE5 = 3'd5;
    localparam t_func FN_SPARE7 = 3'd7;

    localparam logic [MAC_W-1:0] MAC_ONES = {MAC_W{1'b1}};
    localparam logic [MAC_W-1:0] MAC_ZERO = '0;
    localparam logic [ID_W-1:0]  ID_ONES  = {ID_W{1'b1}};
    localparam logic [ID_W-1:0]  ID_ZERO  = '0;
    localparam logic [PAY_W-1:0] PAY_ONES = {PAY_W{1'b1}};
    localparam logic [PAY_W-1:0] PAY_ZERO = '0;
    localparam logic [PAY_W-1:0] PAY_KEEP =
        (PAYLOAD_BITS >= PAY_W) ? {PAY_W{1'b1}} : ((32'd1 << PAYLOAD_BITS) - 32'd1);

    // Table rows: TYPED rows carry their own expectation, PREDICTED rows use the predictor
    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // Random phases: capacity written before each, number of requests, share of adds (%)
    localparam logic [CNT_W-1:0] PHASE_CAP [PHASES] =
        '{7'd0, 7'd1, 7'd127, 7'd64, 7'd5, 7'd33, 7'd100, 7'd64};
    localparam int PHASE_ITEMS [PHASES] = '{50, 60, 110, 150, 90, 100, 90, 100};
    localparam int PHASE_ADDS  [PHASES] = '{45, 50, 50, 80, 40, 55, 50, 45};

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] found;
        logic [MAC_W-1:0] mac;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] pay;
        logic [CNT_W-1:0] count;
        logic             empty;
    } list_result_t;

    typedef struct packed {
        t_func            fn;
        logic [CNT_W-1:0] pos;
        logic [MAC_W-1:0] mac;
        logic [ID_W-1:0]  id;
        logic [PAY_W-1:0] pay;
        logic             is_typed;
        logic             want_ok;
        logic [CNT_W-1:0] want_found;
        logic [CNT_W-1:0] want_count;
    } script_row_t;

    // DUT-facing signals; the ones the bench drives are known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic [FUNC_W-1:0]  i_func      = '0;
    logic [CNT_W-1:0]   i_position  = '0;
    logic [MAC_W-1:0]   i_key_mac   = '0;
    logic [ID_W-1:0]    i_key_id    = '0;
    logic [PAY_W-1:0]   i_payload   = '0;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic               o_ok;
    logic [CNT_W-1:0]   o_found_position;
    logic [MAC_W-1:0]   o_out_mac;
    logic [ID_W-1:0]    o_out_id;
    logic [PAY_W-1:0]   o_out_payload;
    logic [CNT_W-1:0]   o_count;
    logic               o_empty_res;

    keyed_sequential_list u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_position       (i_position),
        .i_key_mac        (i_key_mac),
        .i_key_id         (i_key_id),
        .i_payload        (i_payload),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_ok             (o_ok),
        .o_found_position (o_found_position),
        .o_out_mac        (o_out_mac),
        .o_out_id         (o_out_id),
        .o_out_payload    (o_out_payload),
        .o_count          (o_count),
        .o_empty_res      (o_empty_res)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the list, kept in step with every accepted request
    logic [MAC_W-1:0]   held_mac [DEPTH];
    logic [ID_W-1:0]    held_id  [DEPTH];
    logic [PAY_W-1:0]   held_pay [DEPTH];
    int                 held_count    = 0;
    logic [CNT_W-1:0]   held_capacity = CAP_RST;

    list_result_t       list_expected [$];
    script_row_t        directed_rows [DIR_ROWS];
    logic [MAC_W-1:0]   key_pool_mac [8];
    logic [ID_W-1:0]    key_pool_id  [8];

    bit src_idling  = 1'b1;
    bit sink_idling = 1'b1;
    int sink_stall_left = 0;
    int cycle_count     = 0;
    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int adds_refused    = 0;
    int locate_hits     = 0;

    // Work out the result of one request and move the shadow list on
    function automatic list_result_t list_apply(input t_func fn, input logic [CNT_W-1:0] pos,
                                                input logic [MAC_W-1:0] mac,
                                                input logic [ID_W-1:0] id,
                                                input logic [PAY_W-1:0] pay);
        list_result_t r;
        int lim;
        r = '0;
        // capacity is clipped to the depth of the store
        lim = (int'(held_capacity) < DEPTH) ? int'(held_capacity) : DEPTH;
        case (fn)
            FN_ADD: begin
                if (held_count < lim) begin
                    held_mac[held_count] = mac;
                    held_id[held_count]  = id;
                    held_pay[held_count] = pay & PAY_KEEP;
                    held_count++;
                    r.ok = 1'b1;
                end else begin
                    adds_refused++;
                end
            end
            FN_DEL: begin
                if (pos != 0 && int'(pos) <= held_count) begin
                    for (int i = int'(pos); i < held_count; i++) begin
                        held_mac[i-1] = held_mac[i];
                        held_id[i-1]  = held_id[i];
                        held_pay[i-1] = held_pay[i];
                    end
                    held_count--;
                    r.ok = 1'b1;
                end
            end
            FN_GET: begin
                if (pos != 0 && int'(pos) <= held_count) begin
                    r.mac = held_mac[pos-1];
                    r.id  = held_id[pos-1];
                    r.pay = held_pay[pos-1];
                    r.ok  = 1'b1;
                end
            end
            FN_LOC: begin
                // last match wins
                for (int i = 0; i < held_count; i++) begin
                    if (held_mac[i] == mac && held_id[i] == id)
                        r.found = CNT_W'(i + 1);
                end
                if (r.found != 0)
                    locate_hits++;
                r.ok = 1'b1;
            end
            FN_CLR: begin
                held_count = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = CNT_W'(held_count);
        r.empty = (held_count == 0);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [MAC_W-1:0] got,
                                 input logic [MAC_W-1:0] want);
        if (mismatches < MAX_REPORTS)
            $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Present one request and hold it until the block takes it. Called in the step of the
    // previous acceptance, so valid only ever gets one assignment per step.
    task automatic issue_request(input t_func fn, input logic [CNT_W-1:0] pos,
                                 input logic [MAC_W-1:0] mac, input logic [ID_W-1:0] id,
                                 input logic [PAY_W-1:0] pay, input logic is_typed,
                                 input list_result_t typed_res);
        list_result_t predicted;
        int gap;
        gap = 0;
        if (src_idling && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 16);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_position <= pos;
        i_key_mac  <= mac;
        i_key_id   <= id;
        i_payload  <= pay;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = list_apply(fn, pos, mac, id, pay);
        list_expected.push_back(is_typed ? typed_res : predicted);
        requests_sent++;
    endtask

    // Build one random request. Keys come mostly from a small pool so that locate finds
    // duplicates and partial matches; positions mostly land inside the list.
    task automatic random_request(input int add_pct);
        t_func            fn;
        logic [CNT_W-1:0] pos;
        logic [MAC_W-1:0] mac;
        logic [ID_W-1:0]  id;
        int               roll;
        int               pick;
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
            fn = FN_ADD;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 30)       fn = FN_DEL;
            else if (roll < 58)  fn = FN_GET;
            else if (roll < 94)  fn = FN_LOC;
            else if (roll < 96)  fn = FN_CLR;
            else                 fn = t_func'($urandom_range(FN_SPARE5, FN_SPARE7));
        end

        pick = $urandom_range(0, 9);
        if (pick == 0)
            pos = CNT_W'($urandom_range(0, 127));
        else if (pick == 1)
            pos = $urandom_range(0, 1) ? CNT_W'(held_count + 1) : '0;
        else if (held_count > 0)
            pos = CNT_W'($urandom_range(1, held_count));
        else
            pos = 7'd1;

        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            roll = $urandom_range(0, 7);
            mac  = key_pool_mac[roll];
            id   = key_pool_id[roll];
        end else if (pick == 7) begin
            // MAC of one pool key with the ID of another
            mac = key_pool_mac[$urandom_range(0, 7)];
            id  = key_pool_id[$urandom_range(0, 7)];
        end else begin
            mac = {$urandom, $urandom};
            id  = $urandom;
        end
        issue_request(fn, pos, mac, id, $urandom, PREDICTED, '0);
    endtask

    // Drain the block, then write the capacity register while nothing is in flight
    task automatic set_capacity(input logic [CNT_W-1:0] value);
        i_in_valid <= 1'b0;
        while (list_expected.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        held_capacity = value;
    endtask

    // Result side: check each accepted result against the oldest expectation, and stall
    // the ready line in random bursts
    always @(posedge i_clk) begin : result_check
        list_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (list_expected.size() == 0) begin
                flag_mismatch("unrequested result, count", MAC_W'(o_count), '0);
            end else begin
                want = list_expected.pop_front();
                if (o_ok !== want.ok)
                    flag_mismatch("ok", MAC_W'(o_ok), MAC_W'(want.ok));
                if (o_found_position !== want.found)
                    flag_mismatch("found_position", MAC_W'(o_found_position),
                                  MAC_W'(want.found));
                if (o_out_mac !== want.mac)
                    flag_mismatch("out_mac", o_out_mac, want.mac);
                if (o_out_id !== want.id)
                    flag_mismatch("out_id", MAC_W'(o_out_id), MAC_W'(want.id));
                if (o_out_payload !== want.pay)
                    flag_mismatch("out_payload", MAC_W'(o_out_payload), MAC_W'(want.pay));
                if (o_count !== want.count)
                    flag_mismatch("count", MAC_W'(o_count), MAC_W'(want.count));
                if (o_empty_res !== want.empty)
                    flag_mismatch("empty_res", MAC_W'(o_empty_res), MAC_W'(want.empty));
            end
        end
        if (sink_stall_left > 0)
            sink_stall_left--;
        else if (sink_idling && $urandom_range(0, 9) == 0)
            sink_stall_left = $urandom_range(1, 16);
        i_out_ready <= (sink_stall_left == 0);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, list_expected.size());
            $display("** keyed_sequential_list: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        script_row_t  row;
        list_result_t typed_res;

        key_pool_mac[0] = MAC_ONES;
        key_pool_id[0]  = ID_ONES;
        key_pool_mac[1] = MAC_ZERO;
        key_pool_id[1]  = ID_ZERO;
        for (int k = 2; k < 8; k++) begin
            key_pool_mac[k] = {$urandom, $urandom};
            key_pool_id[k]  = $urandom;
        end

        // Directed table, capacity at its reset value. Typed rows: empty list, extremes,
        // bad positions, last-match locate, clear and the unused func codes.
        //                  fn         pos     mac                     id            pay           chk        ok    found  count
        directed_rows[0]  = {FN_GET,    7'd1,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b0, 7'd0,  7'd0};
        directed_rows[1]  = {FN_DEL,    7'd0,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b0, 7'd0,  7'd0};
        directed_rows[2]  = {FN_LOC,    7'd0,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b1, 7'd0,  7'd0};
        directed_rows[3]  = {FN_ADD,    7'd0,   MAC_ONES,               ID_ONES,      PAY_ONES,     TYPED,     1'b1, 7'd0,  7'd1};
        directed_rows[4]  = {FN_ADD,    7'd127, MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b1, 7'd0,  7'd2};
        directed_rows[5]  = {FN_ADD,    7'd0,   64'h8000_0000_0000_0001, 32'h8000_0001, 32'h5555_5555, TYPED,   1'b1, 7'd0,  7'd3};
        directed_rows[6]  = {FN_ADD,    7'd0,   MAC_ONES,               ID_ONES,      32'hAAAA_AAAA, TYPED,    1'b1, 7'd0,  7'd4};
        directed_rows[7]  = {FN_LOC,    7'd0,   MAC_ONES,               ID_ONES,      PAY_ZERO,     TYPED,     1'b1, 7'd4,  7'd4};
        directed_rows[8]  = {FN_LOC,    7'd0,   MAC_ONES,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b1, 7'd0,  7'd4};
        directed_rows[9]  = {FN_GET,    7'd1,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     PREDICTED, 1'b0, 7'd0,  7'd0};
        directed_rows[10] = {FN_GET,    7'd4,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     PREDICTED, 1'b0, 7'd0,  7'd0};
        directed_rows[11] = {FN_GET,    7'd5,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b0, 7'd0,  7'd4};
        directed_rows[12] = {FN_GET,    7'd64,  MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b0, 7'd0,  7'd4};
        directed_rows[13] = {FN_GET,    7'd127, MAC_ONES,               ID_ONES,      PAY_ONES,     TYPED,     1'b0, 7'd0,  7'd4};
        directed_rows[14] = {FN_DEL,    7'd5,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b0, 7'd0,  7'd4};
        directed_rows[15] = {FN_DEL,    7'd1,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b1, 7'd0,  7'd3};
        directed_rows[16] = {FN_LOC,    7'd0,   MAC_ONES,               ID_ONES,      PAY_ZERO,     TYPED,     1'b1, 7'd3,  7'd3};
        directed_rows[17] = {FN_LOC,    7'd0,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b1, 7'd1,  7'd3};
        directed_rows[18] = {FN_SPARE5, 7'd1,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b0, 7'd0,  7'd3};
        directed_rows[19] = {FN_SPARE7, 7'd64,  MAC_ONES,               ID_ONES,      PAY_ONES,     TYPED,     1'b0, 7'd0,  7'd3};
        directed_rows[20] = {FN_DEL,    7'd3,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b1, 7'd0,  7'd2};
        directed_rows[21] = {FN_GET,    7'd2,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     PREDICTED, 1'b0, 7'd0,  7'd0};
        directed_rows[22] = {FN_CLR,    7'd0,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     TYPED,     1'b1, 7'd0,  7'd0};
        directed_rows[23] = {FN_ADD,    7'd0,   64'h0123_4567_89AB_CDEF, 32'h0BAD_F00D, 32'h1234_5678, TYPED,   1'b1, 7'd0,  7'd1};
        directed_rows[24] = {FN_GET,    7'd1,   MAC_ZERO,               ID_ZERO,      PAY_ZERO,     PREDICTED, 1'b0, 7'd0,  7'd0};

        // Synchronous reset held, then released
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            row             = directed_rows[r];
            typed_res       = '0;
            typed_res.ok    = row.want_ok;
            typed_res.found = row.want_found;
            typed_res.count = row.want_count;
            typed_res.empty = (row.want_count == 0);
            issue_request(row.fn, row.pos, row.mac, row.id, row.pay, row.is_typed, typed_res);
        end

        // Random phases, each under its own capacity; the list carries over between them.
        // The last phase runs with no idling on either side.
        for (int p = 0; p < PHASES; p++) begin
            set_capacity(PHASE_CAP[p]);
            if (p == PHASES - 1) begin
                src_idling  = 1'b0;
                sink_idling = 1'b0;
            end
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
                random_request(PHASE_ADDS[p]);
        end

        i_in_valid <= 1'b0;
        while (list_expected.size() != 0) @(posedge i_clk);
        // margin for a locate or delete that walks the whole list
        repeat (DEPTH + 8) @(posedge i_clk);

        $display("Sent %0d requests (%0d from the table) under %0d capacity settings; %0d results checked",
                 requests_sent, DIR_ROWS, PHASES, results_checked);
        $display("Adds refused for a full list: %0d, locates with a hit: %0d, mismatches: %0d",
                 adds_refused, locate_hits, mismatches);
        if (mismatches == 0 && list_expected.size() == 0)
            $display("** keyed_sequential_list: PASSED **");
        else
            $display("** keyed_sequential_list: FAILED **");
        $finish;
    end

endmodule
